// ===== hw/rtl/pwcc_pkg.sv =====
`default_nettype none

package pwcc_pkg;

	// default parameter values
	localparam int PARTICLES_DEF = 32;
	localparam int GRID_DIM_DEF  = 32;
	localparam int FRAC_BITS_DEF = 12;

	// field widths
	localparam int MODE_W  = 2;
	localparam int PART_W  = 5;
	localparam int STEP_W  = 16;
	localparam int CELL_W  = 5;
	localparam int POS_W   = 24;
	localparam int COUNT_W = 32;

	// input tdata layout, mode travels in tuser
	localparam int IN_PART_LO   = 0;
	localparam int IN_STEPX_LO  = IN_PART_LO + PART_W;
	localparam int IN_STEPY_LO  = IN_STEPX_LO + STEP_W;
	localparam int IN_CELLX_LO  = IN_STEPY_LO + STEP_W;
	localparam int IN_CELLY_LO  = IN_CELLX_LO + CELL_W;
	localparam int IN_BITS      = IN_CELLY_LO + CELL_W;
	localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

	// output tdata layout
	localparam int OUT_POSX_LO  = 0;
	localparam int OUT_POSY_LO  = OUT_POSX_LO + POS_W;
	localparam int OUT_HIT_LO   = OUT_POSY_LO + POS_W;
	localparam int OUT_COUNT_LO = OUT_HIT_LO + 1;
	localparam int OUT_BITS     = OUT_COUNT_LO + COUNT_W;
	localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int EXTENT_W   = 6;
	localparam int RADIUS_W   = 24;
	localparam int START_W    = 17;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_EXTENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_POS   = 2'd2;

	localparam logic [EXTENT_W-1:0] EXTENT_RST = 6'd21;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd4194304;
	localparam logic [START_W-1:0]  START_RST  = 17'd40960;

	// position at reset, in grid units
	localparam int POS_INIT_UNITS = 10;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_MOVE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PLACE = 2'd2;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_MOVE,
		KIND_READ,
		KIND_PLACE
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_ROUND,
		ST_SQUARE,
		ST_CMP,
		ST_INC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr;
		logic add;
		logic round;
		logic square;
		logic cmp;
		logic inc;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		kind_t kind_in;
		kind_t kind_q;
		logic  clr_last;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pwcc_ctrl.sv =====
`default_nettype none

module pwcc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire pwcc_pkg::dp_stat_t  stat,
	output logic                     s_tready,
	output pwcc_pkg::ctrl_cmd_t      cmd
);

	pwcc_pkg::state_t state_q;
	pwcc_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwcc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pwcc_pkg::ST_CLEAR: begin
				if (stat.clr_last) begin
					state_nxt = pwcc_pkg::ST_IDLE;
				end
			end
			pwcc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (stat.kind_in == pwcc_pkg::KIND_MOVE ||
					    stat.kind_in == pwcc_pkg::KIND_PLACE) begin
						state_nxt = pwcc_pkg::ST_ADD;
					end else begin
						state_nxt = pwcc_pkg::ST_DONE;
					end
				end
			end
			pwcc_pkg::ST_ADD: begin
				if (stat.kind_q == pwcc_pkg::KIND_MOVE) begin
					state_nxt = pwcc_pkg::ST_ROUND;
				end else begin
					state_nxt = pwcc_pkg::ST_DONE;
				end
			end
			pwcc_pkg::ST_ROUND:  state_nxt = pwcc_pkg::ST_SQUARE;
			pwcc_pkg::ST_SQUARE: state_nxt = pwcc_pkg::ST_CMP;
			pwcc_pkg::ST_CMP:    state_nxt = pwcc_pkg::ST_INC;
			pwcc_pkg::ST_INC:    state_nxt = pwcc_pkg::ST_DONE;
			pwcc_pkg::ST_DONE: begin
				if (stat.out_free) begin
					state_nxt = pwcc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = pwcc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			pwcc_pkg::ST_CLEAR:  cmd.clr = 1'b1;
			pwcc_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			pwcc_pkg::ST_ADD:    cmd.add = 1'b1;
			pwcc_pkg::ST_ROUND:  cmd.round = 1'b1;
			pwcc_pkg::ST_SQUARE: cmd.square = 1'b1;
			pwcc_pkg::ST_CMP:    cmd.cmp = 1'b1;
			pwcc_pkg::ST_INC:    cmd.inc = 1'b1;
			pwcc_pkg::ST_DONE:   cmd.load = stat.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pwcc_dp.sv =====
`default_nettype none

module pwcc_dp #(
	parameter int PARTICLES = pwcc_pkg::PARTICLES_DEF,
	parameter int GRID_DIM  = pwcc_pkg::GRID_DIM_DEF,
	parameter int FRAC_BITS = pwcc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [pwcc_pkg::MODE_W-1:0]       s_tuser,
	input  wire logic [pwcc_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [pwcc_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [pwcc_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  wire logic [pwcc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire pwcc_pkg::ctrl_cmd_t               cmd,
	output pwcc_pkg::dp_stat_t                     stat
);

	localparam int PD     = (PARTICLES < 32) ? PARTICLES : 32;
	localparam int PIW    = (PD > 1) ? $clog2(PD) : 1;
	localparam int CELLS  = GRID_DIM * GRID_DIM;
	localparam int AW     = $clog2(CELLS);
	localparam int EXT_W  = $clog2(GRID_DIM + 1);
	localparam int CMP_W  = (EXT_W > pwcc_pkg::EXTENT_W) ? EXT_W : pwcc_pkg::EXTENT_W;
	localparam int LIM_W  = EXT_W + FRAC_BITS;
	localparam int LW     = (LIM_W > pwcc_pkg::POS_W) ? LIM_W : pwcc_pkg::POS_W;
	localparam int RS_W   = pwcc_pkg::POS_W + 1;
	localparam int IX_W   = RS_W - FRAC_BITS;
	localparam int SQ_W   = 2 * FRAC_BITS;
	localparam int SUM_W  = (SQ_W + 1 > pwcc_pkg::RADIUS_W) ? SQ_W + 1 : pwcc_pkg::RADIUS_W;
	localparam int PW     = pwcc_pkg::POS_W;

	localparam logic [PW-1:0]        POS_INIT = PW'(pwcc_pkg::POS_INIT_UNITS << FRAC_BITS);
	localparam logic [RS_W-1:0]      HALF_U   = RS_W'(1 << (FRAC_BITS - 1));
	localparam logic [FRAC_BITS:0]   ONE_U    = (FRAC_BITS + 1)'(1 << FRAC_BITS);
	localparam logic [pwcc_pkg::COUNT_W-1:0] CNT_MAX = '1;

	// configuration
	logic [pwcc_pkg::EXTENT_W-1:0] grid_extent_q;
	logic [pwcc_pkg::RADIUS_W-1:0] radius_sq_q;
	logic [pwcc_pkg::START_W-1:0]  start_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_extent_q <= pwcc_pkg::EXTENT_RST;
			radius_sq_q   <= pwcc_pkg::RADIUS_RST;
			start_pos_q   <= pwcc_pkg::START_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				pwcc_pkg::REG_GRID_EXTENT:
					grid_extent_q <= cfg_wdata[pwcc_pkg::EXTENT_W-1:0];
				pwcc_pkg::REG_RADIUS_SQ:
					radius_sq_q <= cfg_wdata[pwcc_pkg::RADIUS_W-1:0];
				pwcc_pkg::REG_START_POS:
					start_pos_q <= cfg_wdata[pwcc_pkg::START_W-1:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [pwcc_pkg::MODE_W-1:0] mode_in;
	logic [pwcc_pkg::PART_W-1:0] part_in;
	logic [pwcc_pkg::STEP_W-1:0] step_x_in;
	logic [pwcc_pkg::STEP_W-1:0] step_y_in;
	logic [pwcc_pkg::CELL_W-1:0] cell_x_in;
	logic [pwcc_pkg::CELL_W-1:0] cell_y_in;
	logic                        part_ok;
	logic                        cell_ok;
	logic [AW-1:0]               cell_addr;
	pwcc_pkg::kind_t             kind_in;

	assign mode_in   = s_tuser;
	assign part_in   = s_tdata[pwcc_pkg::IN_PART_LO +: pwcc_pkg::PART_W];
	assign step_x_in = s_tdata[pwcc_pkg::IN_STEPX_LO +: pwcc_pkg::STEP_W];
	assign step_y_in = s_tdata[pwcc_pkg::IN_STEPY_LO +: pwcc_pkg::STEP_W];
	assign cell_x_in = s_tdata[pwcc_pkg::IN_CELLX_LO +: pwcc_pkg::CELL_W];
	assign cell_y_in = s_tdata[pwcc_pkg::IN_CELLY_LO +: pwcc_pkg::CELL_W];

	assign part_ok   = 32'(part_in) < 32'(PARTICLES);
	assign cell_ok   = (32'(cell_x_in) < 32'(GRID_DIM)) && (32'(cell_y_in) < 32'(GRID_DIM));
	assign cell_addr = AW'(32'(cell_y_in) * 32'(GRID_DIM) + 32'(cell_x_in));

	always_comb begin
		priority if (mode_in == pwcc_pkg::MODE_MOVE && part_ok) begin
			kind_in = pwcc_pkg::KIND_MOVE;
		end else if (mode_in == pwcc_pkg::MODE_READ && cell_ok) begin
			kind_in = pwcc_pkg::KIND_READ;
		end else if (mode_in == pwcc_pkg::MODE_PLACE && part_ok) begin
			kind_in = pwcc_pkg::KIND_PLACE;
		end else begin
			kind_in = pwcc_pkg::KIND_NONE;
		end
	end

	// captured request
	pwcc_pkg::kind_t             kind_q;
	logic [PIW-1:0]              part_q;
	logic [pwcc_pkg::STEP_W-1:0] step_x_q;
	logic [pwcc_pkg::STEP_W-1:0] step_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= pwcc_pkg::KIND_NONE;
		end else if (cmd.accept) begin
			kind_q <= kind_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			part_q   <= part_in[PIW-1:0];
			step_x_q <= step_x_in;
			step_y_q <= step_y_in;
		end
	end

	// position memory, x in the low half
	logic [2*PW-1:0] pos_mem [PD];
	logic [2*PW-1:0] pos_rd_q;
	logic [PD-1:0]   pos_vld_q;
	logic [PW-1:0]   pos_x_q;
	logic [PW-1:0]   pos_y_q;
	logic [PW-1:0]   cur_x;
	logic [PW-1:0]   cur_y;
	logic [PW-1:0]   new_x;
	logic [PW-1:0]   new_y;

	function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a,
	                                          input logic [pwcc_pkg::STEP_W-1:0] b);
		logic [PW:0] s;
		s = {a[PW-1], a} + (PW + 1)'(signed'(b));
		if (s[PW] != s[PW-1]) begin
			return s[PW] ? {1'b1, {(PW - 1){1'b0}}} : {1'b0, {(PW - 1){1'b1}}};
		end
		return s[PW-1:0];
	endfunction

	assign cur_x = pos_vld_q[part_q] ? pos_rd_q[PW-1:0]  : POS_INIT;
	assign cur_y = pos_vld_q[part_q] ? pos_rd_q[2*PW-1:PW] : POS_INIT;

	always_comb begin
		if (kind_q == pwcc_pkg::KIND_PLACE) begin
			new_x = PW'(start_pos_q);
			new_y = PW'(start_pos_q);
		end else begin
			new_x = sat_add(cur_x, step_x_q);
			new_y = sat_add(cur_y, step_y_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_rd_q <= pos_mem[part_in[PIW-1:0]];
		end
		if (cmd.add) begin
			pos_mem[part_q] <= {new_y, new_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q <= '0;
		end else if (cmd.add) begin
			pos_vld_q[part_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			pos_x_q <= new_x;
			pos_y_q <= new_y;
		end
	end

	// grid rounding and distance
	logic [CMP_W-1:0]     ext_w;
	logic [EXT_W-1:0]     ext;
	logic [LW-1:0]        lim;
	logic [RS_W-1:0]      rsum_x;
	logic [RS_W-1:0]      rsum_y;
	logic [FRAC_BITS-1:0] frac_x;
	logic [FRAC_BITS-1:0] frac_y;
	logic [FRAC_BITS-1:0] d_x;
	logic [FRAC_BITS-1:0] d_y;
	logic                 in_grid;

	assign ext_w = (CMP_W'(grid_extent_q) > CMP_W'(GRID_DIM)) ?
	               CMP_W'(GRID_DIM) : CMP_W'(grid_extent_q);
	assign ext   = ext_w[EXT_W-1:0];
	assign lim   = LW'(ext) << FRAC_BITS;

	assign rsum_x = RS_W'(pos_x_q[PW-2:0]) + HALF_U;
	assign rsum_y = RS_W'(pos_y_q[PW-2:0]) + HALF_U;
	assign frac_x = pos_x_q[FRAC_BITS-1:0];
	assign frac_y = pos_y_q[FRAC_BITS-1:0];
	assign d_x    = frac_x[FRAC_BITS-1] ? FRAC_BITS'(ONE_U - {1'b0, frac_x}) : frac_x;
	assign d_y    = frac_y[FRAC_BITS-1] ? FRAC_BITS'(ONE_U - {1'b0, frac_y}) : frac_y;
	assign in_grid = !pos_x_q[PW-1] && !pos_y_q[PW-1] &&
	                 (LW'(pos_x_q[PW-2:0]) < lim) && (LW'(pos_y_q[PW-2:0]) < lim);

	logic [IX_W-1:0]      ix_q;
	logic [IX_W-1:0]      iy_q;
	logic [FRAC_BITS-1:0] dx_q;
	logic [FRAC_BITS-1:0] dy_q;
	logic                 in_grid_q;
	logic [SQ_W-1:0]      dx2_q;
	logic [SQ_W-1:0]      dy2_q;
	logic [AW-1:0]        addr_q;
	logic                 hit_q;
	logic [SUM_W-1:0]     dist_sq;
	logic                 hit_c;

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			ix_q      <= rsum_x[RS_W-1:FRAC_BITS];
			iy_q      <= rsum_y[RS_W-1:FRAC_BITS];
			dx_q      <= d_x;
			dy_q      <= d_y;
			in_grid_q <= in_grid;
		end
		if (cmd.square) begin
			dx2_q  <= dx_q * dx_q;
			dy2_q  <= dy_q * dy_q;
			addr_q <= AW'(32'(iy_q) * 32'(GRID_DIM) + 32'(ix_q));
		end
	end

	assign dist_sq = SUM_W'(dx2_q) + SUM_W'(dy2_q);
	assign hit_c   = in_grid_q && (32'(ix_q) < 32'(ext)) && (32'(iy_q) < 32'(ext)) &&
	                 (dist_sq <= SUM_W'(radius_sq_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.cmp) begin
			hit_q <= hit_c;
		end
	end

	// cell counter memory
	logic [pwcc_pkg::COUNT_W-1:0] cnt_mem [CELLS];
	logic [pwcc_pkg::COUNT_W-1:0] cnt_rd_q;
	logic [pwcc_pkg::COUNT_W-1:0] cnt_inc;
	logic [pwcc_pkg::COUNT_W-1:0] cnt_q;
	logic [AW-1:0]                clr_addr_q;
	logic [AW-1:0]                rd_addr;

	assign rd_addr = cmd.accept ? cell_addr : addr_q;
	assign cnt_inc = (cnt_rd_q == CNT_MAX) ? cnt_rd_q : cnt_rd_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.accept || cmd.cmp) begin
			cnt_rd_q <= cnt_mem[rd_addr];
		end
		if (cmd.clr) begin
			cnt_mem[clr_addr_q] <= '0;
		end else if (cmd.inc && hit_q) begin
			cnt_mem[addr_q] <= cnt_inc;
		end
		if (cmd.inc) begin
			cnt_q <= cnt_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// result register
	logic                          m_tvalid_q;
	logic [pwcc_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                          res_pos;
	logic                          res_hit;
	logic [pwcc_pkg::COUNT_W-1:0]  res_cnt;

	assign res_pos = (kind_q == pwcc_pkg::KIND_MOVE) || (kind_q == pwcc_pkg::KIND_PLACE);
	assign res_hit = (kind_q == pwcc_pkg::KIND_MOVE) && hit_q;

	always_comb begin
		unique case (kind_q)
			pwcc_pkg::KIND_MOVE: res_cnt = hit_q ? cnt_q : '0;
			pwcc_pkg::KIND_READ: res_cnt = cnt_rd_q;
			default:             res_cnt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata_q <= pwcc_pkg::OUT_DATA_W'({res_cnt, res_hit,
			                                    res_pos ? pos_y_q : {PW{1'b0}},
			                                    res_pos ? pos_x_q : {PW{1'b0}}});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign stat.kind_in  = kind_in;
	assign stat.kind_q   = kind_q;
	assign stat.clr_last = (32'(clr_addr_q) == 32'(CELLS - 1));
	assign stat.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

// ===== hw/rtl/particle_walk_cell_counter.sv =====
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tuser: mode; s_tdata: request (particle, steps, cell)
// m        out        m_tvalid/m_tready  m_tdata: result (positions, hit, count)
// cfg      in         cfg_we             cfg_addr, cfg_wdata
//
// one request at a time; before the next accept a move passes the add, round, square,
// cmp, inc and done controller states, a place add and done, a read or unused code done.
// after reset the counter memory is cleared one entry a cycle, all GRID_DIM*GRID_DIM
// entries (1024 by default), with s_tready low.
// a result waits in the output register; a stalled m side holds the block in
// its final step only if the previous result is still there.
`default_nettype none

module particle_walk_cell_counter #(
	parameter int PARTICLES = pwcc_pkg::PARTICLES_DEF,
	parameter int GRID_DIM  = pwcc_pkg::GRID_DIM_DEF,
	parameter int FRAC_BITS = pwcc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// mode
	input  wire logic [pwcc_pkg::MODE_W-1:0]      s_tuser,
	// particle, step_x, step_y, cell_x, cell_y
	input  wire logic [pwcc_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pos_x, pos_y, hit, count_value
	output logic [pwcc_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [pwcc_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [pwcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	pwcc_pkg::ctrl_cmd_t cmd;
	pwcc_pkg::dp_stat_t  stat;

	pwcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	pwcc_dp #(
		.PARTICLES (PARTICLES),
		.GRID_DIM  (GRID_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in progress");

	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[pwcc_pkg::OUT_HIT_LO] |->
			!m_tdata[pwcc_pkg::OUT_POSX_LO + pwcc_pkg::POS_W - 1] &&
			!m_tdata[pwcc_pkg::OUT_POSY_LO + pwcc_pkg::POS_W - 1])
		else $error("hit reported for a negative position");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[pwcc_pkg::OUT_HIT_LO] |->
			m_tdata[pwcc_pkg::OUT_COUNT_LO +: pwcc_pkg::COUNT_W] != '0)
		else $error("hit reported with a zero count");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> stat.out_free)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== dv/particle_walk_cell_counter_tb.sv =====
`timescale 1ns / 100ps

module particle_walk_cell_counter_tb;

	import pwcc_pkg::*;

	localparam int PARTICLES = PARTICLES_DEF;
	localparam int GRID = GRID_DIM_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint POS_HI = 64'sd8388607;
	localparam longint POS_LO = -64'sd8388608;
	localparam longint HALF = 64'sd1 <<< (FRAC - 1);
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_ITEMS = 200;
	localparam int SAT_ITEMS = 280;

	typedef struct packed {
		logic [CELL_W-1:0]        cell_y;
		logic [CELL_W-1:0]        cell_x;
		logic signed [STEP_W-1:0] step_y;
		logic signed [STEP_W-1:0] step_x;
		logic [PART_W-1:0]        particle;
		logic [MODE_W-1:0]        mode;
	} walk_req_t;

	localparam int REQ_BITS = $bits(walk_req_t);

	typedef struct {
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic               hit;
		logic [COUNT_W-1:0] count_value;
	} walk_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [MODE_W-1:0] s_tuser = '0;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	particle_walk_cell_counter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// predicted block state
	logic signed [POS_W-1:0] part_x [PARTICLES];
	logic signed [POS_W-1:0] part_y [PARTICLES];
	logic [COUNT_W-1:0] cell_hits [GRID*GRID];
	logic [EXTENT_W-1:0] reg_extent = EXTENT_RST;
	logic [RADIUS_W-1:0] reg_radius = RADIUS_RST;
	logic [START_W-1:0] reg_start = START_RST;

	walk_res_t pending_results [$];
	walk_res_t want;
	int errors = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	bit bursty = 1'b1;

	initial begin
		for (int i = 0; i < PARTICLES; i++) begin
			part_x[i] = POS_W'(POS_INIT_UNITS << FRAC);
			part_y[i] = POS_W'(POS_INIT_UNITS << FRAC);
		end
		for (int i = 0; i < GRID * GRID; i++)
			cell_hits[i] = '0;
	end

	function automatic longint sat_pos(longint p, longint s);
		longint sum;
		sum = p + s;
		if (sum > POS_HI)
			return POS_HI;
		if (sum < POS_LO)
			return POS_LO;
		return sum;
	endfunction

	function automatic longint grid_dist(longint p, output int idx);
		longint d;
		idx = int'((p + HALF) >>> FRAC);
		d = p - (longint'(idx) <<< FRAC);
		return (d < 0) ? -d : d;
	endfunction

	function automatic int extent_in_use();
		return (reg_extent > GRID) ? GRID : int'(reg_extent);
	endfunction

	function automatic walk_res_t apply_request(walk_req_t rq);
		walk_res_t r;
		int ext, ix, iy, a;
		longint lim, px, py, dx, dy;
		r.pos_x = '0;
		r.pos_y = '0;
		r.hit = 1'b0;
		r.count_value = '0;
		case (rq.mode)
			MODE_MOVE: begin
				ext = extent_in_use();
				lim = longint'(ext) <<< FRAC;
				px = sat_pos(longint'(part_x[rq.particle]), longint'($signed(rq.step_x)));
				py = sat_pos(longint'(part_y[rq.particle]), longint'($signed(rq.step_y)));
				part_x[rq.particle] = POS_W'(px);
				part_y[rq.particle] = POS_W'(py);
				r.pos_x = POS_W'(px);
				r.pos_y = POS_W'(py);
				if (px >= 0 && py >= 0 && px < lim && py < lim) begin
					dx = grid_dist(px, ix);
					dy = grid_dist(py, iy);
					if (ix < ext && iy < ext && dx * dx + dy * dy <= longint'(reg_radius)) begin
						a = iy * GRID + ix;
						if (cell_hits[a] != '1)
							cell_hits[a] = cell_hits[a] + 1'b1;
						r.count_value = cell_hits[a];
						r.hit = 1'b1;
					end
				end
			end
			MODE_READ: begin
				r.count_value = cell_hits[int'(rq.cell_y) * GRID + int'(rq.cell_x)];
			end
			MODE_PLACE: begin
				part_x[rq.particle] = POS_W'(reg_start);
				part_y[rq.particle] = POS_W'(reg_start);
				r.pos_x = POS_W'(reg_start);
				r.pos_y = POS_W'(reg_start);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic walk_req_t random_req();
		return walk_req_t'(REQ_BITS'({$urandom(), $urandom()}));
	endfunction

	function automatic walk_req_t make_req(logic [MODE_W-1:0] mode, int particle,
		int sx, int sy, int cx, int cy);
		walk_req_t rq;
		rq.mode = mode;
		rq.particle = PART_W'(particle);
		rq.step_x = STEP_W'(sx);
		rq.step_y = STEP_W'(sy);
		rq.cell_x = CELL_W'(cx);
		rq.cell_y = CELL_W'(cy);
		return rq;
	endfunction

	task automatic send_request(walk_req_t rq);
		while (bursty && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.mode;
		s_tdata <= IN_DATA_W'({rq.cell_y, rq.cell_x, rq.step_y, rq.step_x, rq.particle});
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_request(rq));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRID_EXTENT: reg_extent = val[EXTENT_W-1:0];
			REG_RADIUS_SQ:   reg_radius = val[RADIUS_W-1:0];
			REG_START_POS:   reg_start = val[START_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(int extent, int radius, int start);
		wait_drained();
		write_reg(REG_GRID_EXTENT, CFG_DATA_W'(extent));
		write_reg(REG_RADIUS_SQ, CFG_DATA_W'(radius));
		write_reg(REG_START_POS, CFG_DATA_W'(start));
	endtask

	// reset register values, radius and rounding edges
	task automatic test_reset_directed();
		send_request(make_req(MODE_READ, 0, 0, 0, 10, 10));
		send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 31, 31));
		send_request(make_req(MODE_MOVE, 0, 0, 0, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 10, 10));
		send_request(make_req(MODE_MOVE, 31, 32767, 32767, 0, 0));
		send_request(make_req(MODE_MOVE, 1, -32768, -32768, 0, 0));
		send_request(make_req(MODE_MOVE, 1, -32768, -32768, 0, 0));
		send_request(make_req(MODE_PLACE, 1, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 2, 2048, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 3, 2048, 2048, 0, 0));
		send_request(make_req(MODE_MOVE, 4, 24576, 24576, 0, 0));
		// just below the extent, rounds onto it
		send_request(make_req(MODE_MOVE, 4, 19456, 19456, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 21, 21));
		send_request(make_req(MODE_READ, 0, 0, 0, 20, 20));
		begin
			walk_req_t rq;
			rq = random_req();
			rq.mode = MODE_UNUSED;
			send_request(rq);
		end
		wait_drained();
	endtask

	task automatic test_register_extremes();
		set_regs(0, 24'hFFFFFF, 0);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
		send_request(make_req(MODE_PLACE, 7, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 7, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 7, 100, 100, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));

		// extent above the grid is clamped
		set_regs(63, 8388608, 131071);
		send_request(make_req(MODE_PLACE, 8, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 8, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 8, -2048, -2048, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 31, 31));

		set_regs(1, 0, 0);
		send_request(make_req(MODE_PLACE, 9, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 9, 0, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 9, 1, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 9, -1, 0, 0, 0));
		send_request(make_req(MODE_MOVE, 9, -1, -1, 0, 0));
		send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_saturation();
		walk_req_t rq;
		set_regs(32, 8388608, 65536);
		send_request(make_req(MODE_PLACE, 5, 0, 0, 0, 0));
		for (int i = 0; i < SAT_ITEMS; i++) begin
			rq = random_req();
			rq.mode = MODE_MOVE;
			rq.particle = PART_W'(5);
			rq.step_x = STEP_W'(24576 + int'($urandom_range(8191)));
			rq.step_y = STEP_W'(-24576 - int'($urandom_range(8192)));
			send_request(rq);
		end
		send_request(make_req(MODE_PLACE, 5, 0, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random_walk(bit pressure);
		walk_req_t rq;
		int pick, ext;
		if (pressure)
			hold_request = 1'b1;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			rq = random_req();
			pick = $urandom_range(99);
			ext = extent_in_use();
			if (pick < 60) begin
				rq.mode = MODE_MOVE;
				rq.step_x = STEP_W'(int'($urandom_range(12288)) - 6144);
				rq.step_y = STEP_W'(int'($urandom_range(12288)) - 6144);
			end else if (pick < 70) begin
				rq.mode = MODE_MOVE;
			end else if (pick < 85) begin
				rq.mode = MODE_READ;
				if (ext > 0 && $urandom_range(3) != 0) begin
					rq.cell_x = CELL_W'($urandom_range(ext - 1));
					rq.cell_y = CELL_W'($urandom_range(ext - 1));
				end
			end else if (pick < 96) begin
				rq.mode = MODE_PLACE;
			end else begin
				rq.mode = MODE_UNUSED;
			end
			send_request(rq);
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (bursty) begin
			m_tready <= ($urandom_range(99) >= 33);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[OUT_POSX_LO +: POS_W] !== want.pos_x) begin
					$error("pos_x expected %h got %h", want.pos_x, m_tdata[OUT_POSX_LO +: POS_W]);
					errors++;
				end
				if (m_tdata[OUT_POSY_LO +: POS_W] !== want.pos_y) begin
					$error("pos_y expected %h got %h", want.pos_y, m_tdata[OUT_POSY_LO +: POS_W]);
					errors++;
				end
				if (m_tdata[OUT_HIT_LO] !== want.hit) begin
					$error("hit expected %b got %b", want.hit, m_tdata[OUT_HIT_LO]);
					errors++;
				end
				if (m_tdata[OUT_COUNT_LO +: COUNT_W] !== want.count_value) begin
					$error("count_value expected %0d got %0d", want.count_value,
						m_tdata[OUT_COUNT_LO +: COUNT_W]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_directed();
		test_register_extremes();
		test_saturation();
		set_regs(32, 8388608, 65536);
		test_random_walk(1'b0);
		bursty = 1'b0;
		set_regs(12, 2097152 + $urandom_range(6291456), 24576);
		test_random_walk(1'b0);
		bursty = 1'b1;
		begin
			int ext;
			ext = $urandom_range(1, 32);
			set_regs(ext, $urandom_range(24'hFFFFFF), $urandom_range(ext << FRAC));
		end
		test_random_walk(1'b1);
		set_regs($urandom_range(33, 63), $urandom_range(24'hFFFFFF), $urandom_range(131071));
		test_random_walk(1'b0);
		if (pending_results.size() != 0)
			errors++;
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
